// ===== rtl/cfq_pkg.sv =====
// Shared command and status codes, field widths and sequencer states for the circular FIFO.
`default_nettype none
package cfq_pkg;

	localparam int CMD_W   = 3;
	localparam int WORD_W  = 32;
	localparam int TOTAL_W = 5;
	localparam int STAT_W  = 2;

	// tdata of a result: three words, count, three flags, status, padded to bytes
	localparam int RES_BITS = 3 * WORD_W + TOTAL_W + 3 + STAT_W;
	localparam int RES_W    = ((RES_BITS + 7) / 8) * 8;

	localparam logic [CMD_W-1:0] CMD_NONE = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ENQ  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DEQ  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_HAS  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLR  = 3'd4;

	localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_FRONT = 3'b010,
		ST_SCAN  = 3'b100
	} seq_state_t;

endpackage
`default_nettype wire

// ===== rtl/cfq_ram.sv =====
// Slot storage: one write port, one read port with registered read data.
`default_nettype none
module cfq_ram #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                         clk,
	input  wire logic                         wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
	input  wire logic [DATA_WIDTH-1:0]        wr_data,
	input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
	output logic      [DATA_WIDTH-1:0]        rd_data
);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

// ===== rtl/circular_fifo_queue.sv =====
// Top level of the circular FIFO queue: command decode, sequencer, pointers and result register.
`default_nettype none
// Ring-buffer FIFO of DEPTH words of DATA_WIDTH bits. Each request carries a command in
// s_tuser (none, enqueue, dequeue, contains, clear) and a word in s_tdata, and yields one
// result on the m_ side with the dequeued word, the front and rear words, the count, the
// empty and full flags, the contains hit and a status code. Slots live in a single-port-read
// RAM; front and rear words are kept in registers so most commands finish at once.
// None, clear, enqueue, errors, contains on an empty queue and a dequeue that empties the
// queue answer straight from the idle state. A dequeue that leaves words behind passes
// through ST_FRONT, which loads the new front word read through the RAM read port. Contains
// passes through ST_SCAN, comparing entries up to and including the first match (all of
// them when nothing matches): the RAM read port and the single word comparator step through
// the live entries from the head, one per cycle. s_tready is low while a dequeue or search
// is in flight and while an undelivered result is stalled.
// An enqueue to a full queue is rejected with status 2; a dequeue from empty gives status 1.
// No clearing pass is needed after reset: only live slots are ever read.
module circular_fifo_queue #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [cfq_pkg::WORD_W-1:0] s_tdata,   // [31:0] data_in
	input  wire logic [cfq_pkg::CMD_W-1:0]  s_tuser,   // [2:0] cmd
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// [31:0] data_out, [63:32] front_word, [95:64] rear_word, [100:96] entry_total,
	// [101] is_empty, [102] is_full, [103] found, [105:104] status, [111:106] zero
	output logic      [cfq_pkg::RES_W-1:0]  m_tdata
);
	import cfq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

	// sequencer and pointer state
	seq_state_t       st_q;
	logic [AW-1:0]    head_q;
	logic [AW-1:0]    tail_q;
	logic [CW-1:0]    count_q;
	logic [AW-1:0]    scan_pos_q;
	logic [CW-1:0]    left_q;
	logic             out_valid_q;

	// payload registers
	logic [DATA_WIDTH-1:0] front_q;
	logic [DATA_WIDTH-1:0] rear_q;
	logic [DATA_WIDTH-1:0] word_q;     // search key held during a scan
	logic [WORD_W-1:0]     taken_q;
	logic                  found_q;
	logic [STAT_W-1:0]     status_q;

	// decode
	logic                  accept;
	logic [DATA_WIDTH-1:0] word_in;
	logic                  q_empty;
	logic                  q_full;
	logic [AW-1:0]         head_nxt;
	logic [AW-1:0]         tail_nxt;
	logic [AW-1:0]         scan_nxt;
	logic                  hit;
	logic                  scan_end;

	// RAM hookup
	logic                  ram_we;
	logic [AW-1:0]         ram_rd_addr;
	logic [DATA_WIDTH-1:0] ram_rd_data;

	function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
		next_pos = (p == LAST_SLOT) ? '0 : p + AW'(1);
	endfunction

	assign s_tready = (st_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign word_in  = DATA_WIDTH'(s_tdata);
	assign q_empty  = (count_q == '0);
	assign q_full   = (count_q == CW'(DEPTH));
	assign head_nxt = next_pos(head_q);
	assign tail_nxt = next_pos(tail_q);
	assign scan_nxt = next_pos(scan_pos_q);

	// the shared comparator: one live entry per cycle against the held key
	assign hit      = (ram_rd_data == word_q);
	assign scan_end = hit || (left_q == CW'(1));

	assign ram_we = accept && (s_tuser == CMD_ENQ) && !q_full;

	// the dequeue prefetches the new front, the search starts at the head
	always_comb begin
		if (st_q == ST_SCAN) begin
			ram_rd_addr = scan_pos_q;
		end else if (s_tuser == CMD_DEQ) begin
			ram_rd_addr = head_nxt;
		end else begin
			ram_rd_addr = head_q;
		end
	end

	cfq_ram #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (tail_nxt),
		.wr_data (word_in),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// control: sequencer, pointers, count, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= LAST_SLOT;
			count_q     <= '0;
			scan_pos_q  <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						out_valid_q <= 1'b1;
						case (s_tuser)
							CMD_ENQ: begin
								if (!q_full) begin
									tail_q  <= tail_nxt;
									count_q <= count_q + CW'(1);
								end
							end
							CMD_DEQ: begin
								if (count_q == CW'(1)) begin
									head_q  <= '0;
									tail_q  <= LAST_SLOT;
									count_q <= '0;
								end else if (!q_empty) begin
									head_q      <= head_nxt;
									count_q     <= count_q - CW'(1);
									out_valid_q <= 1'b0;
									st_q        <= ST_FRONT;
								end
							end
							CMD_HAS: begin
								if (!q_empty) begin
									scan_pos_q  <= head_nxt;
									left_q      <= count_q;
									out_valid_q <= 1'b0;
									st_q        <= ST_SCAN;
								end
							end
							CMD_CLR: begin
								head_q  <= '0;
								tail_q  <= LAST_SLOT;
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_FRONT: begin
					out_valid_q <= 1'b1;
					st_q        <= ST_IDLE;
				end
				ST_SCAN: begin
					if (scan_end) begin
						out_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
					end else begin
						left_q     <= left_q - CW'(1);
						scan_pos_q <= scan_nxt;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload: cached front/rear words and result fields
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (accept) begin
					taken_q  <= '0;
					found_q  <= 1'b0;
					status_q <= STATUS_OK;
					case (s_tuser)
						CMD_ENQ: begin
							if (q_full) begin
								status_q <= STATUS_FULL;
							end else begin
								rear_q <= word_in;
								if (q_empty) begin
									front_q <= word_in;
								end
							end
						end
						CMD_DEQ: begin
							if (q_empty) begin
								status_q <= STATUS_EMPTY;
							end else begin
								taken_q <= WORD_W'(front_q);
							end
						end
						CMD_HAS: begin
							word_q <= word_in;
						end
						default: begin
						end
					endcase
				end
			end
			ST_FRONT: begin
				front_q <= ram_rd_data;
			end
			ST_SCAN: begin
				if (scan_end) begin
					found_q <= hit;
				end
			end
			default: begin
			end
		endcase
	end

	// result fields; state only moves once the pending result is taken
	logic [WORD_W-1:0]  front_word;
	logic [WORD_W-1:0]  rear_word;
	logic [TOTAL_W-1:0] entry_total;

	assign front_word  = q_empty ? '0 : WORD_W'(front_q);
	assign rear_word   = q_empty ? '0 : WORD_W'(rear_q);
	assign entry_total = TOTAL_W'(count_q);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = RES_W'({status_q, found_q, q_full, q_empty, entry_total,
		rear_word, front_word, taken_q});

	// checks
	logic [CW:0]   tail_sum;
	logic [AW-1:0] tail_expect;

	always_comb begin
		tail_sum = {1'b0, CW'(head_q)} + {1'b0, count_q} - (CW + 1)'(1);
		if (tail_sum >= (CW + 1)'(DEPTH)) begin
			tail_expect = AW'(tail_sum - (CW + 1)'(DEPTH));
		end else begin
			tail_expect = AW'(tail_sum);
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> (head_q == '0 && tail_q == LAST_SLOT))
		else $error("empty queue with pointers not at home");

	a_tail_track: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> (tail_q == tail_expect))
		else $error("tail does not follow head plus count");

	a_scan_live: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SCAN) |-> (left_q != '0 && left_q <= count_q && !out_valid_q))
		else $error("scan running past live entries or over a pending result");

endmodule
`default_nettype wire
